/* rtl/core/epoch_reclaim_tracker_top_macros.svh */
// assertion macros shared by the epoch reclaim tracker rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef EPOCH_RECLAIM_TRACKER_TOP_MACROS_SVH
`define EPOCH_RECLAIM_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ERT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ERT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ert_pkg.sv */
// shared constants, codes and types for the epoch reclaim tracker
// no dependencies
package ert_pkg;

    localparam int READERS      = 16;
    localparam int QUEUE_DEPTH  = 32;
    localparam int OBJECT_BITS  = 16;
    localparam int VERSION_BITS = 32;
    localparam int MAX_RESULTS  = 32;

    localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int RCNT_W = $clog2(READERS + 1);
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NCNT_W = $clog2(MAX_RESULTS + 1);

    localparam int OP_W   = 3;
    localparam int RID_W  = 4;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_LOCK    = 3'd0;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUBLISH = 3'd2;
    localparam logic [OP_W-1:0] OP_RETIRE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RECLAIM = 3'd4;
    localparam logic [OP_W-1:0] OP_DRAIN   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SAT   = 3'd4;

    typedef logic [VERSION_BITS-1:0] version_t;
    typedef logic [OBJECT_BITS-1:0]  object_t;

    localparam version_t VERSION_MAX = '1;

    typedef struct packed {
        object_t  obj;
        version_t version;
        logic     dtor;
    } ret_entry_t;

    typedef struct packed {
        logic push;
        logic rd_head;
        logic pop;
    } q_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic              lock;
        logic              unlock;
        logic              rd;
        logic [RIDX_W-1:0] idx;
    } rdr_cmd_t;

endpackage

/* rtl/core/epoch_reclaim_tracker_top.sv */
// lock, unlock, publish, retire and unknown opcodes: one result, in the cycle after start;
// busy stays low, so one such transaction can be taken every cycle
// reclaim: scans the reader slots, then reads and checks queue entries one at a time through
// the queue memory read port before finishing; drain skips the scan
// results are strobed for one cycle on result_valid; async reset clears version,
// reader flags and queue pointers, memory contents stay as they are
`include "epoch_reclaim_tracker_top_macros.svh"

module epoch_reclaim_tracker_top
    import ert_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [RID_W-1:0]  reader_id,
    input  object_t           object_id,
    input  logic              has_destructor,
    output logic              result_valid,
    output logic [KIND_W-1:0] kind,
    output object_t           freed_object,
    output logic              freed_destructor,
    output version_t          version_now,
    output logic              last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RSCAN = 2'd1;
    localparam logic [1:0] S_QREAD = 2'd2;
    localparam logic [1:0] S_QEVAL = 2'd3;

    logic [1:0]        state_reg, state_next;
    version_t          gv_reg, gv_next;
    version_t          limit_reg, limit_next;
    logic [RCNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [NCNT_W-1:0] n_reg, n_next;
    logic              have_pend_reg, have_pend_next;
    object_t           pend_obj_reg, pend_obj_next;
    logic              pend_dtor_reg, pend_dtor_next;

    logic              res_valid_reg, res_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    object_t           fobj_reg, fobj_next;
    logic              fdtor_reg, fdtor_next;
    version_t          vnow_reg, vnow_next;
    logic              last_reg, last_next;

    rdr_cmd_t          rdr_cmd;
    logic              rdr_active;
    version_t          rdr_version;
    q_cmd_t            q_cmd;
    q_stat_t           q_stat;
    ret_entry_t        q_wr_entry;
    ret_entry_t        q_rd_entry;

    logic              accept;
    logic              rid_ok;
    logic              scan_issue;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign rid_ok     = (32'(reader_id) < 32'(READERS));
    assign scan_issue = (scan_cnt_reg < RCNT_W'(READERS));

    assign q_wr_entry.obj     = object_id;
    assign q_wr_entry.version = gv_reg;
    assign q_wr_entry.dtor    = has_destructor;

    ert_reader_table u_readers (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (rdr_cmd),
        .wr_version (gv_reg),
        .rd_active  (rdr_active),
        .rd_version (rdr_version)
    );

    ert_retire_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_cmd),
        .wr_entry (q_wr_entry),
        .stat     (q_stat),
        .rd_entry (q_rd_entry)
    );

    always_comb
    begin
        state_next     = state_reg;
        gv_next        = gv_reg;
        limit_next     = limit_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = 1'b0;
        n_next         = n_reg;
        have_pend_next = have_pend_reg;
        pend_obj_next  = pend_obj_reg;
        pend_dtor_next = pend_dtor_reg;

        res_valid_next = 1'b0;
        kind_next      = KIND_ACK;
        fobj_next      = '0;
        fdtor_next     = 1'b0;
        vnow_next      = gv_reg;
        last_next      = 1'b1;

        rdr_cmd        = '0;
        rdr_cmd.idx    = RIDX_W'(reader_id);
        q_cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b1;
                    case (opcode) inside
                        OP_LOCK:
                        begin
                            rdr_cmd.lock = rid_ok;
                        end
                        OP_UNLOCK:
                        begin
                            rdr_cmd.unlock = rid_ok;
                        end
                        OP_PUBLISH:
                        begin
                            if (gv_reg == VERSION_MAX)
                            begin
                                kind_next = KIND_SAT;
                            end
                            else
                            begin
                                gv_next   = gv_reg + 1'b1;
                                vnow_next = gv_next;
                            end
                        end
                        OP_RETIRE:
                        begin
                            if (q_stat.full)
                            begin
                                kind_next = KIND_FULL;
                            end
                            else
                            begin
                                q_cmd.push = 1'b1;
                            end
                        end
                        OP_RECLAIM, OP_DRAIN:
                        begin
                            // results come later from the queue walk
                            res_valid_next = 1'b0;
                            limit_next     = gv_reg;
                            scan_cnt_next  = '0;
                            n_next         = '0;
                            have_pend_next = 1'b0;
                            state_next     = (opcode == OP_RECLAIM) ? S_RSCAN : S_QREAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RSCAN:
            begin
                // one slot read per cycle, the compare lands in the cycle after its read
                rdr_cmd.idx = scan_cnt_reg[RIDX_W-1:0];
                if (scan_issue)
                begin
                    rdr_cmd.rd    = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end
                if (rd_pend_reg && rdr_active && (rdr_version < limit_reg))
                begin
                    limit_next = rdr_version;
                end
                if (!scan_issue && !rd_pend_reg)
                begin
                    state_next = S_QREAD;
                end
            end
            S_QREAD:
            begin
                if (q_stat.empty || (n_reg == NCNT_W'(MAX_RESULTS)))
                begin
                    res_valid_next = 1'b1;
                    if (have_pend_reg)
                    begin
                        kind_next  = KIND_FREED;
                        fobj_next  = pend_obj_reg;
                        fdtor_next = pend_dtor_reg;
                    end
                    else
                    begin
                        kind_next = KIND_NONE;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    q_cmd.rd_head = 1'b1;
                    state_next    = S_QEVAL;
                end
            end
            S_QEVAL:
            begin
                if (q_rd_entry.version < limit_reg)
                begin
                    // the previous freed object is not the last one
                    if (have_pend_reg)
                    begin
                        res_valid_next = 1'b1;
                        kind_next      = KIND_FREED;
                        fobj_next      = pend_obj_reg;
                        fdtor_next     = pend_dtor_reg;
                        last_next      = 1'b0;
                    end
                    have_pend_next = 1'b1;
                    pend_obj_next  = q_rd_entry.obj;
                    pend_dtor_next = q_rd_entry.dtor;
                    q_cmd.pop      = 1'b1;
                    n_next         = n_reg + 1'b1;
                    state_next     = S_QREAD;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if (have_pend_reg)
                    begin
                        kind_next  = KIND_FREED;
                        fobj_next  = pend_obj_reg;
                        fdtor_next = pend_dtor_reg;
                    end
                    else
                    begin
                        kind_next = KIND_NONE;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gv_reg        <= '0;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            n_reg         <= '0;
            have_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gv_reg        <= gv_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            n_reg         <= n_next;
            have_pend_reg <= have_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        pend_obj_reg  <= pend_obj_next;
        pend_dtor_reg <= pend_dtor_next;
        kind_reg      <= kind_next;
        fobj_reg      <= fobj_next;
        fdtor_reg     <= fdtor_next;
        vnow_reg      <= vnow_next;
        last_reg      <= last_next;
    end

    assign result_valid     = res_valid_reg;
    assign kind             = kind_reg;
    assign freed_object     = fobj_reg;
    assign freed_destructor = fdtor_reg;
    assign version_now      = vnow_reg;
    assign last             = last_reg;

    `ERT_ASSERT_IMP(a_pop_not_empty, q_cmd.pop, !q_stat.empty, "pop from empty retire queue")
    `ERT_ASSERT_IMP(a_push_not_full, q_cmd.push, !q_stat.full, "push into full retire queue")
    `ERT_ASSERT_IMP(a_last_when_idle, result_valid && last, !busy, "final result while still busy")
    `ERT_ASSERT_IMP(a_more_when_busy, result_valid && !last, busy, "non-final result with walk ended")
    `ERT_ASSERT_NXT(a_lock_acks, accept && (opcode == OP_LOCK),
        result_valid && last && (kind == KIND_ACK), "lock did not answer ack next cycle")

endmodule

/* rtl/core/ert_reader_table.sv */
// per-reader version slots: version memory with registered read, active flags
// depends on ert_pkg
module ert_reader_table
    import ert_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rdr_cmd_t cmd,
    input  version_t wr_version,
    output logic     rd_active,
    output version_t rd_version
);

    version_t            mem [READERS];
    logic [READERS-1:0]  active_reg;
    logic [READERS-1:0]  active_next;
    logic                rd_active_reg;
    version_t            rd_version_reg;

    always_comb
    begin
        active_next = active_reg;
        if (cmd.lock)
        begin
            active_next[cmd.idx] = 1'b1;
        end
        if (cmd.unlock)
        begin
            active_next[cmd.idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            rd_active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            if (cmd.rd)
            begin
                rd_active_reg <= active_reg[cmd.idx];
            end
        end
    end

    // slots of inactive readers are never used, so the memory needs no clearing
    always_ff @(posedge clk)
    begin
        if (cmd.lock)
        begin
            mem[cmd.idx] <= wr_version;
        end
        if (cmd.rd)
        begin
            rd_version_reg <= mem[cmd.idx];
        end
    end

    assign rd_active  = rd_active_reg;
    assign rd_version = rd_version_reg;

endmodule

/* rtl/core/ert_retire_queue.sv */
// circular queue of retired objects: entry memory, head pointer and fill count
// depends on ert_pkg
module ert_retire_queue
    import ert_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_cmd_t     cmd,
    input  ret_entry_t wr_entry,
    output q_stat_t    stat,
    output ret_entry_t rd_entry
);

    ret_entry_t          mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0]   head_reg;
    logic [QIDX_W-1:0]   head_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QIDX_W:0]     tail_sum;
    logic [QIDX_W:0]     tail_wrap;
    ret_entry_t          rd_entry_reg;

    // head + count stays below twice the depth, one subtract wraps it
    assign tail_sum  = {1'b0, head_reg} + (QIDX_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (QIDX_W + 1)'(QUEUE_DEPTH))
                     ? tail_sum - (QIDX_W + 1)'(QUEUE_DEPTH) : tail_sum;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next  = (head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_wrap[QIDX_W-1:0]] <= wr_entry;
        end
        if (cmd.rd_head)
        begin
            rd_entry_reg <= mem[head_reg];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule
